// ===== design/prc_pkg.sv =====
// ----------------------------------------------------------------------------
// prc_pkg
// Shared constants, types and the arctangent table for the polar and
// rectangular conversion pipeline.
// ----------------------------------------------------------------------------
package prc_pkg;

  localparam int unsigned DATA_WIDTH = 16;
  localparam int unsigned ITERATIONS = 16;
  localparam int unsigned GUARD      = 8;
  localparam int unsigned XW         = DATA_WIDTH + GUARD + 3;
  localparam int unsigned ZW         = 32;
  localparam int unsigned RES_W      = DATA_WIDTH + 1;
  localparam int unsigned SHIFT_W    = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;
  localparam int unsigned GAIN_W     = 32;
  localparam int unsigned PROD_W     = XW + GAIN_W;

  localparam logic [ZW-1:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [ZW-1:0] QUARTER_TURN = 32'h4000_0000;

  localparam logic signed [GAIN_W-1:0] INV_GAIN_Q31 = 32'sd1304065748;

  typedef enum logic {
    OP_TO_POLAR = 1'b0,
    OP_TO_RECT  = 1'b1
  } opcode_e;

  typedef struct packed {
    opcode_e                mode;
    logic                   zero;
    logic signed [XW-1:0]   x;
    logic signed [XW-1:0]   y;
    logic        [ZW-1:0]   z;
  } cordic_t;

  function automatic logic [ZW-1:0] atan_turns(input logic [4:0] idx);
    logic [ZW-1:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/prc_cordic_stage.sv =====
// ----------------------------------------------------------------------------
// prc_cordic_stage
// One registered CORDIC micro-rotation, in vectoring or rotation mode as the
// item carries it.
// ----------------------------------------------------------------------------
module prc_cordic_stage (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [prc_pkg::SHIFT_W-1:0] shift_i,
  input  logic [prc_pkg::ZW-1:0]      atan_i,
  input  logic                        valid_i,
  input  prc_pkg::cordic_t            data_i,
  output logic                        valid_o,
  output prc_pkg::cordic_t            data_o
);

  logic signed [prc_pkg::XW-1:0] x_in;
  logic signed [prc_pkg::XW-1:0] y_in;
  logic signed [prc_pkg::XW-1:0] sx;
  logic signed [prc_pkg::XW-1:0] sy;
  logic                          add_x;
  prc_pkg::cordic_t              data_d;
  prc_pkg::cordic_t              data_q;
  logic                          valid_q;

  always_comb begin
    x_in  = data_i.x;
    y_in  = data_i.y;
    sx    = x_in >>> shift_i;
    sy    = y_in >>> shift_i;
    if (data_i.mode == prc_pkg::OP_TO_POLAR) begin
      add_x = !y_in[prc_pkg::XW-1];
    end else begin
      add_x = data_i.z[prc_pkg::ZW-1];
    end
    data_d = data_i;
    if (add_x) begin
      data_d.x = x_in + sy;
      data_d.y = y_in - sx;
      data_d.z = data_i.z + atan_i;
    end else begin
      data_d.x = x_in - sy;
      data_d.y = y_in + sx;
      data_d.z = data_i.z - atan_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== design/polar_rectangular_converter_core.sv =====
// ----------------------------------------------------------------------------
// polar_rectangular_converter_core
// Converts rectangular pairs to magnitude and angle, and magnitude and angle
// back to rectangular pairs, with a fully unrolled CORDIC pipeline.
// ----------------------------------------------------------------------------
// The block takes one transfer per clock cycle while the output is not stalled
// and returns each result in order, after passing through one input
// register, one register per CORDIC micro-rotation stage, one register after
// the gain-correction multipliers and the output register. Angles are binary
// units in which 65536 is one turn. When a valid output is stalled the whole
// pipeline holds, and the input stall follows that output stall.
module polar_rectangular_converter_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                opcode_i,
  input  logic signed [prc_pkg::DATA_WIDTH-1:0] first_value_i,
  input  logic signed [prc_pkg::DATA_WIDTH-1:0] second_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [prc_pkg::RES_W-1:0]    first_result_o,
  output logic signed [prc_pkg::RES_W-1:0]    second_result_o
);

  localparam int unsigned PW = prc_pkg::PROD_W;
  localparam int unsigned RW = prc_pkg::RES_W;
  localparam int unsigned XW = prc_pkg::XW;
  localparam int unsigned ZW = prc_pkg::ZW;
  localparam int unsigned DW = prc_pkg::DATA_WIDTH;
  localparam int unsigned NS = prc_pkg::ITERATIONS;

  localparam logic signed [PW-1:0] ROUND_BIAS = PW'(1) <<< (30 + prc_pkg::GUARD);
  localparam logic signed [PW-1:0] SAT_HI     = PW'((1 << (RW - 1)) - 1);
  localparam logic signed [PW-1:0] SAT_LO     = -SAT_HI - PW'(1);

  function automatic logic signed [RW-1:0] scale_out(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] sum;
    logic signed [PW-1:0] r;
    sum = p + ROUND_BIAS;
    r   = sum >>> (31 + prc_pkg::GUARD);
    if (r > SAT_HI) begin
      return SAT_HI[RW-1:0];
    end else if (r < SAT_LO) begin
      return SAT_LO[RW-1:0];
    end
    return r[RW-1:0];
  endfunction

  logic                        en;
  logic                        stage_valid [NS+1];
  prc_pkg::cordic_t            stage_data  [NS+1];

  logic signed [XW-1:0]        a_x;
  logic signed [XW-1:0]        b_x;
  logic        [ZW-1:0]        z_rot;
  logic        [ZW-1:0]        z_wide;
  prc_pkg::cordic_t            in_d;
  prc_pkg::cordic_t            in_q;
  logic                        in_valid_q;

  logic                        mul_valid_q;
  prc_pkg::opcode_e            mul_mode_q;
  logic                        mul_zero_q;
  logic signed [PW-1:0]        mx_d;
  logic signed [PW-1:0]        my_d;
  logic signed [PW-1:0]        mx_q;
  logic signed [PW-1:0]        my_q;
  logic        [ZW-1:0]        z_round;
  logic        [DW-1:0]        ang_q;

  logic                        out_valid_q;
  logic signed [RW-1:0]        first_d;
  logic signed [RW-1:0]        second_d;
  logic signed [RW-1:0]        first_q;
  logic signed [RW-1:0]        second_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  always_comb begin
    a_x    = XW'(first_value_i) <<< prc_pkg::GUARD;
    b_x    = XW'(second_value_i) <<< prc_pkg::GUARD;
    z_rot  = {second_value_i, {(ZW - DW){1'b0}}};
    z_wide = z_rot + prc_pkg::QUARTER_TURN;
    in_d   = '0;
    if (opcode_i == prc_pkg::OP_TO_POLAR) begin
      in_d.mode = prc_pkg::OP_TO_POLAR;
      in_d.zero = (first_value_i == '0) && (second_value_i == '0);
      if (first_value_i[DW-1]) begin
        in_d.x = -a_x;
        in_d.y = -b_x;
        in_d.z = prc_pkg::HALF_TURN;
      end else begin
        in_d.x = a_x;
        in_d.y = b_x;
        in_d.z = '0;
      end
    end else begin
      in_d.mode = prc_pkg::OP_TO_RECT;
      in_d.zero = 1'b0;
      in_d.y    = '0;
      if (z_wide[ZW-1]) begin
        in_d.x = -a_x;
        in_d.z = z_rot ^ prc_pkg::HALF_TURN;
      end else begin
        in_d.x = a_x;
        in_d.z = z_rot;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (en) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q <= in_d;
    end
  end

  assign stage_valid[0] = in_valid_q;
  assign stage_data[0]  = in_q;

  for (genvar i = 0; i < NS; i++) begin : g_stage
    prc_cordic_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .shift_i (prc_pkg::SHIFT_W'(i)),
      .atan_i  (prc_pkg::atan_turns(5'(i))),
      .valid_i (stage_valid[i]),
      .data_i  (stage_data[i]),
      .valid_o (stage_valid[i+1]),
      .data_o  (stage_data[i+1])
    );
  end

  always_comb begin
    mx_d    = stage_data[NS].x * prc_pkg::INV_GAIN_Q31;
    my_d    = stage_data[NS].y * prc_pkg::INV_GAIN_Q31;
    z_round = stage_data[NS].z + ZW'(32768);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      mul_valid_q <= stage_valid[NS];
      out_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mul_mode_q <= stage_data[NS].mode;
      mul_zero_q <= stage_data[NS].zero;
      mx_q       <= mx_d;
      my_q       <= my_d;
      ang_q      <= z_round[ZW-1 -: DW];
    end
  end

  always_comb begin
    if (mul_zero_q) begin
      first_d  = '0;
      second_d = '0;
    end else if (mul_mode_q == prc_pkg::OP_TO_POLAR) begin
      first_d  = scale_out(mx_q);
      second_d = RW'(signed'(ang_q));
    end else begin
      first_d  = scale_out(mx_q);
      second_d = scale_out(my_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign first_result_o  = first_q;
  assign second_result_o = second_q;

endmodule

// ===== sim/polar_rectangular_converter_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polar_rectangular_converter_core_tb
// Self-checking testbench for the CORDIC polar and rectangular converter. A
// short table of edge cases is followed by random conversions, under four
// flow-control phases. Every result is compared with an in-order prediction.
// ----------------------------------------------------------------------------
module polar_rectangular_converter_core_tb;

  localparam int unsigned DATA_WIDTH = prc_pkg::DATA_WIDTH;
  localparam int unsigned RES_W      = prc_pkg::RES_W;
  localparam int unsigned ITERATIONS = prc_pkg::ITERATIONS;
  localparam int unsigned GUARD      = prc_pkg::GUARD;

  localparam logic [31:0] HALF_TURN    = prc_pkg::HALF_TURN;
  localparam logic [31:0] QUARTER_TURN = prc_pkg::QUARTER_TURN;

  localparam int DIRECTED_N   = 25;
  localparam int RANDOM_N     = 1800;
  localparam int PHASE_LEN    = RANDOM_N / 4;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = ITERATIONS + 8;

  localparam logic signed [DATA_WIDTH-1:0] V_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] V_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic signed [RES_W-1:0] first;
    logic signed [RES_W-1:0] second;
  } conv_result_t;

  typedef struct packed {
    prc_pkg::opcode_e             op;
    logic signed [DATA_WIDTH-1:0] first;
    logic signed [DATA_WIDTH-1:0] second;
    logic                         known;
    conv_result_t                 result;
  } stim_row_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic                         opcode_i;
  logic signed [DATA_WIDTH-1:0] first_value_i;
  logic signed [DATA_WIDTH-1:0] second_value_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic signed [RES_W-1:0]      first_result_o;
  logic signed [RES_W-1:0]      second_result_o;

  logic [31:0]  rotation_angle [32];
  stim_row_t    directed_rows [DIRECTED_N];
  conv_result_t expected_conversions [$];

  int send_idle_pct  = 0;
  int stall_pct      = 0;
  int cycle_count    = 0;
  int mismatch_count = 0;
  int received_count = 0;
  int polar_count    = 0;
  int rect_count     = 0;

  polar_rectangular_converter_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .first_value_i  (first_value_i),
    .second_value_i (second_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .first_result_o (first_result_o),
    .second_result_o(second_result_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, expected_conversions.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic signed [RES_W-1:0] remove_gain(input longint x);
    longint prod;
    longint r;
    prod = x * 64'sd1304065748;
    r = (prod + (64'sd1 <<< (30 + GUARD))) >>> (31 + GUARD);
    if (r > 65535) r = 65535;
    if (r < -65536) r = -65536;
    return r[RES_W-1:0];
  endfunction

  function automatic conv_result_t cordic_convert(
    input prc_pkg::opcode_e             op,
    input logic signed [DATA_WIDTH-1:0] a,
    input logic signed [DATA_WIDTH-1:0] b
  );
    conv_result_t res;
    longint       x;
    longint       y;
    longint       t;
    longint       r;
    logic [31:0]  z;
    logic [31:0]  q;
    int           i;
    res = '0;
    x = longint'(a) <<< GUARD;
    if (op == prc_pkg::OP_TO_POLAR) begin
      if (a == 0 && b == 0) return res;
      y = longint'(b) <<< GUARD;
      z = '0;
      if (x < 0) begin
        x = -x;
        y = -y;
        z = HALF_TURN;
      end
      for (i = 0; i < ITERATIONS; i++) begin
        t = x;
        if (y >= 0) begin
          x = x + (y >>> i);
          y = y - (t >>> i);
          z = z + rotation_angle[i];
        end else begin
          x = x - (y >>> i);
          y = y + (t >>> i);
          z = z - rotation_angle[i];
        end
      end
      q = (z + 32'd32768) >> 16;
      res.first  = remove_gain(x);
      res.second = {q[15], q[15:0]};
    end else begin
      y = 0;
      z = {b, 16'h0000};
      if ((z + QUARTER_TURN) >= HALF_TURN) begin
        x = -x;
        z = z - HALF_TURN;
      end
      r = longint'($signed(z));
      for (i = 0; i < ITERATIONS; i++) begin
        t = x;
        if (r >= 0) begin
          x = x - (y >>> i);
          y = y + (t >>> i);
          r = r - longint'(rotation_angle[i]);
        end else begin
          x = x + (y >>> i);
          y = y - (t >>> i);
          r = r + longint'(rotation_angle[i]);
        end
      end
      res.first  = remove_gain(x);
      res.second = remove_gain(y);
    end
    return res;
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70) return DATA_WIDTH'($urandom);
    if (sel < 85) return DATA_WIDTH'(int'($urandom_range(127)) - 64);
    case ($urandom_range(4))
      0: return V_MIN;
      1: return '1;
      2: return '0;
      3: return DATA_WIDTH'(1);
      default: return V_MAX;
    endcase
  endfunction

  task automatic send_conversion(input prc_pkg::opcode_e             op,
                                 input logic signed [DATA_WIDTH-1:0] a,
                                 input logic signed [DATA_WIDTH-1:0] b,
                                 input conv_result_t                 want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i     <= 1'b0;
      opcode_i       <= 1'($urandom);
      first_value_i  <= DATA_WIDTH'($urandom);
      second_value_i <= DATA_WIDTH'($urandom);
      @(posedge clk_i);
    end
    expected_conversions.push_back(want);
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    first_value_i  <= a;
    second_value_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (op == prc_pkg::OP_TO_POLAR) polar_count++;
    else rect_count++;
  endtask

  initial begin
    stim_row_t                    row;
    conv_result_t                 want;
    prc_pkg::opcode_e             op;
    logic signed [DATA_WIDTH-1:0] a;
    logic signed [DATA_WIDTH-1:0] b;
    int                           i;
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    opcode_i       <= 1'b0;
    first_value_i  <= '0;
    second_value_i <= '0;

    // Arctangent of 2^-i in units where 2^32 is one full turn.
    for (i = 0; i < 32; i++) begin
      rotation_angle[i] = 32'(longint'($atan(1.0 / (2.0 ** i)) * 4294967296.0
                                       / 6.283185307179586));
    end

    directed_rows[0]  = '{prc_pkg::OP_TO_POLAR, 16'sd0, 16'sd0, 1'b1, '{17'sd0, 17'sd0}};
    directed_rows[1]  = '{prc_pkg::OP_TO_POLAR, V_MAX, 16'sd0, 1'b0, '0};
    directed_rows[2]  = '{prc_pkg::OP_TO_POLAR, V_MIN, 16'sd0, 1'b0, '0};
    directed_rows[3]  = '{prc_pkg::OP_TO_POLAR, 16'sd0, V_MAX, 1'b0, '0};
    directed_rows[4]  = '{prc_pkg::OP_TO_POLAR, 16'sd0, V_MIN, 1'b0, '0};
    directed_rows[5]  = '{prc_pkg::OP_TO_POLAR, V_MAX, V_MAX, 1'b0, '0};
    directed_rows[6]  = '{prc_pkg::OP_TO_POLAR, V_MIN, V_MIN, 1'b0, '0};
    directed_rows[7]  = '{prc_pkg::OP_TO_POLAR, V_MIN, V_MAX, 1'b0, '0};
    directed_rows[8]  = '{prc_pkg::OP_TO_POLAR, V_MAX, V_MIN, 1'b0, '0};
    directed_rows[9]  = '{prc_pkg::OP_TO_POLAR, -16'sd1, 16'sd0, 1'b0, '0};
    directed_rows[10] = '{prc_pkg::OP_TO_POLAR, 16'sd1, 16'sd1, 1'b0, '0};
    directed_rows[11] = '{prc_pkg::OP_TO_POLAR, -16'sd1, -16'sd1, 1'b0, '0};
    directed_rows[12] = '{prc_pkg::OP_TO_POLAR, 16'sd0, 16'sd1, 1'b0, '0};
    directed_rows[13] = '{prc_pkg::OP_TO_RECT, 16'sd0, 16'sd0, 1'b1, '{17'sd0, 17'sd0}};
    directed_rows[14] = '{prc_pkg::OP_TO_RECT, 16'sd0, V_MIN, 1'b1, '{17'sd0, 17'sd0}};
    directed_rows[15] = '{prc_pkg::OP_TO_RECT, V_MAX, 16'sd0, 1'b0, '0};
    directed_rows[16] = '{prc_pkg::OP_TO_RECT, V_MAX, 16'sd16383, 1'b0, '0};
    directed_rows[17] = '{prc_pkg::OP_TO_RECT, V_MAX, 16'sd16384, 1'b0, '0};
    directed_rows[18] = '{prc_pkg::OP_TO_RECT, V_MAX, -16'sd16384, 1'b0, '0};
    directed_rows[19] = '{prc_pkg::OP_TO_RECT, V_MAX, -16'sd16385, 1'b0, '0};
    directed_rows[20] = '{prc_pkg::OP_TO_RECT, V_MAX, V_MIN, 1'b0, '0};
    directed_rows[21] = '{prc_pkg::OP_TO_RECT, V_MIN, 16'sd0, 1'b0, '0};
    directed_rows[22] = '{prc_pkg::OP_TO_RECT, V_MIN, 16'sd8192, 1'b0, '0};
    directed_rows[23] = '{prc_pkg::OP_TO_RECT, -16'sd1, V_MAX, 1'b0, '0};
    directed_rows[24] = '{prc_pkg::OP_TO_RECT, V_MAX, V_MAX, 1'b0, '0};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < DIRECTED_N; i++) begin
      row  = directed_rows[i];
      want = row.known ? row.result : cordic_convert(row.op, row.first, row.second);
      send_conversion(row.op, row.first, row.second, want);
    end

    for (i = 0; i < RANDOM_N; i++) begin
      case (i / PHASE_LEN)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 51;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 51;
        end
        default: begin
          send_idle_pct = 29;
          stall_pct     = 29;
        end
      endcase
      op = prc_pkg::opcode_e'($urandom_range(1));
      a  = pick_value();
      b  = pick_value();
      send_conversion(op, a, b, cordic_convert(op, a, b));
    end
    in_valid_i <= 1'b0;

    while (expected_conversions.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d conversions (%0d to polar, %0d to rectangular), checked %0d results",
             polar_count + rect_count, polar_count, rect_count, received_count);
    $display("Flow control covered free running, sender gaps, output stalls and both combined");
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    conv_result_t want;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (expected_conversions.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Unexpected transfer at cycle %0d: (%0d, %0d)",
                     cycle_count, first_result_o, second_result_o);
          end
        end else begin
          want = expected_conversions.pop_front();
          received_count++;
          if (first_result_o !== want.first || second_result_o !== want.second) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("Result %0d mismatch: expected (%0d, %0d), got (%0d, %0d)",
                       received_count, want.first, want.second,
                       first_result_o, second_result_o);
            end
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

endmodule
